### sv/maf_pkg.sv
// Shared types for the moving-average filter: controller/datapath command and status.
package maf_pkg;

  localparam int WIN_CODE_W = 2;

  typedef struct packed {
    logic accept;
    logic update;
    logic load;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

### sv/maf_ctrl.sv
// Sequencing state machine for the moving-average filter.
module maf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  maf_pkg::dp_sts_t sts,
  output maf_pkg::dp_cmd_t cmd
);
  import maf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_LOAD   = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (sample_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign sample_stall = rst || (state != S_IDLE);

  a_accept_then_update: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.update)
    else $error("accepted transaction not followed by sum update");

endmodule

### sv/maf_datapath.sv
// Ring store, running sum, fill count, serial divider and output register.
module maf_datapath #(
  parameter int MAX_WINDOW  = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  input  logic                               window_log2_we,
  input  logic        [maf_pkg::WIN_CODE_W-1:0] window_log2,
  input  maf_pkg::dp_cmd_t                   cmd,
  output maf_pkg::dp_sts_t                   sts,
  output logic                               average_valid,
  input  logic                               average_stall,
  output logic signed [SAMPLE_BITS-1:0]      average
);
  import maf_pkg::*;

  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int ITER_W = $clog2(SUM_W + 1);

  logic [SAMPLE_BITS-1:0] store [MAX_WINDOW];

  logic [WIN_CODE_W-1:0]   win_code;
  logic [SLOT_W-1:0]       slot;
  logic [CNT_W-1:0]        fill;
  logic signed [SUM_W-1:0] sum;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0]  old_q;
  logic                    full_q;
  logic [SUM_W-1:0]        quot;
  logic [CNT_W-1:0]        rem;
  logic                    neg;
  logic [ITER_W-1:0]       iter;

  logic [WIN_CODE_W-1:0] lg_eff;
  logic [3:0]            pow;
  logic [CNT_W-1:0]      win_len;
  logic [SLOT_W-1:0]     slot_eff;
  logic [CNT_W-1:0]      slot_inc;
  logic                  full;
  logic signed [SUM_W-1:0] old_ext;
  logic signed [SUM_W-1:0] new_ext;
  logic [CNT_W:0]        rem_sh;
  logic                  ge;
  logic [SAMPLE_BITS-1:0] quot_lo;

  always_comb begin
    lg_eff   = (win_code == '0) ? WIN_CODE_W'(1) : win_code;
    pow      = 4'd1 << lg_eff;
    win_len  = (32'(pow) > MAX_WINDOW) ? CNT_W'(MAX_WINDOW) : CNT_W'(pow);
    slot_eff = (CNT_W'(slot) >= win_len) ? '0 : slot;
    slot_inc = CNT_W'(slot_eff) + CNT_W'(1);
    full     = (fill >= win_len);
    old_ext  = SUM_W'(signed'(old_q));
    new_ext  = SUM_W'(sample_q);
    rem_sh   = {rem, quot[SUM_W-1]};
    ge       = (rem_sh >= (CNT_W+1)'(fill));
    quot_lo  = quot[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      old_q          <= store[slot_eff];
      store[slot_eff] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_code <= WIN_CODE_W'(1);
      slot     <= '0;
      fill     <= '0;
      sum      <= '0;
      iter     <= '0;
    end else if (window_log2_we) begin
      win_code <= window_log2;
      slot     <= '0;
      fill     <= '0;
      sum      <= '0;
    end else begin
      if (cmd.accept) begin
        slot <= (slot_inc >= win_len) ? '0 : slot_inc[SLOT_W-1:0];
        if (!full) begin
          fill <= fill + CNT_W'(1);
        end
      end
      if (cmd.update) begin
        sum <= sum + new_ext - (full_q ? old_ext : '0);
      end
      if (cmd.load) begin
        iter <= ITER_W'(SUM_W);
      end else if (cmd.step) begin
        iter <= iter - ITER_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q <= sample;
      full_q   <= full;
    end
    if (cmd.load) begin
      neg  <= sum[SUM_W-1];
      quot <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      rem  <= '0;
    end else if (cmd.step) begin
      rem  <= ge ? CNT_W'(rem_sh - (CNT_W+1)'(fill)) : rem_sh[CNT_W-1:0];
      quot <= {quot[SUM_W-2:0], ge};
    end
    if (cmd.emit) begin
      average <= neg ? -quot_lo : quot_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_valid <= 1'b0;
    end else if (cmd.emit) begin
      average_valid <= 1'b1;
    end else if (!average_stall) begin
      average_valid <= 1'b0;
    end
  end

  assign sts.div_last = (iter == ITER_W'(1));
  assign sts.out_free = !average_valid || !average_stall;

  a_fill_in_window: assert property (@(posedge clk) disable iff (rst)
    fill <= win_len)
    else $error("fill count beyond window length");

  a_slot_in_window: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(slot) < win_len)
    else $error("write slot outside window");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over an untaken transaction");

endmodule

### sv/moving_average_filter_core.sv
// Moving-average filter over a window of 2, 4 or 8 signed samples.
//
// Input channel: sample with sample_valid / sample_stall; a transaction moves
// on a clock edge with valid high and stall low. Output channel: average with
// average_valid / average_stall, same rule. Each input gives one average:
// the sum of the held samples divided by how many are held, truncated toward
// zero, so warm-up averages are exact.
// One input is taken at a time: sample_stall stays high from the accept
// until the result is loaded into the output register. The steps are the
// accept, the sum update, the divider load, the serial restoring divider,
// one quotient bit per cycle, and the load of the output register.
// The output register holds the result while average_stall is high; the
// next input is still taken and processed, and it waits in the divider until
// the register frees up.
// Reset (rst, synchronous) empties the history and sets window_log2 to 1.
// A write on window_log2_we loads window_log2 and empties the history; write
// it only while no transaction is in flight.
module moving_average_filter_core #(
  parameter int MAX_WINDOW  = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  output logic                               average_valid,
  input  logic                               average_stall,
  output logic signed [SAMPLE_BITS-1:0]      average,
  input  logic                               window_log2_we,
  input  logic        [maf_pkg::WIN_CODE_W-1:0] window_log2
);
  import maf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  maf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  maf_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .sample         (sample),
    .window_log2_we (window_log2_we),
    .window_log2    (window_log2),
    .cmd            (cmd),
    .sts            (sts),
    .average_valid  (average_valid),
    .average_stall  (average_stall),
    .average        (average)
  );

endmodule

### tb/sv/moving_average_filter_core_tb.sv
// Testbench for moving_average_filter_core: random and directed samples against a window-sum scoreboard.
module moving_average_filter_core_tb;

  localparam int MAX_WINDOW  = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;

  typedef logic [maf_pkg::WIN_CODE_W-1:0] win_code_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam win_code_t WIN_UNUSED = 2'd0;
  localparam win_code_t WIN_2      = 2'd1;
  localparam win_code_t WIN_4      = 2'd2;
  localparam win_code_t WIN_8      = 2'd3;

  localparam sample_t SAMPLE_MAX = 24'sh7fffff;
  localparam sample_t SAMPLE_MIN = 24'sh800000;

  class avg_scoreboard;
    sample_t     history [MAX_WINDOW];
    longint      window_sum;
    int unsigned next_slot;
    int unsigned held;
    win_code_t   win_code;
    sample_t     expected_avgs [$];
    int          failures;

    function new();
      failures = 0;
      set_window(WIN_2);
    endfunction

    function void set_window(win_code_t code);
      win_code = code;
      foreach (history[i]) history[i] = '0;
      window_sum = 0;
      next_slot = 0;
      held = 0;
    endfunction

    function int unsigned window_len();
      int unsigned lg;
      int unsigned len;
      lg = win_code;
      if (lg == 0) lg = 1;
      len = 1 << lg;
      if (len > MAX_WINDOW) len = MAX_WINDOW;
      return len;
    endfunction

    function void note_sample(sample_t x);
      int unsigned len;
      int unsigned s;
      longint q;
      len = window_len();
      s = next_slot;
      if (s >= len) s = 0;
      if (held >= len) window_sum -= history[s];
      else held++;
      history[s] = x;
      window_sum += x;
      s++;
      if (s >= len) s = 0;
      next_slot = s;
      q = window_sum / longint'(held);
      expected_avgs.push_back(q[SAMPLE_BITS-1:0]);
    endfunction

    function void check_average(sample_t actual);
      sample_t exp_avg;
      if (expected_avgs.size() == 0) begin
        $error("average: expected none, got %0d", actual);
        failures++;
        return;
      end
      exp_avg = expected_avgs.pop_front();
      if (actual !== exp_avg) begin
        $error("average: expected %0d, got %0d", exp_avg, actual);
        failures++;
      end
    endfunction

    function int pending();
      return expected_avgs.size();
    endfunction
  endclass

  logic      clk;
  logic      rst = 1'b1;
  logic      sample_valid = 1'b0;
  logic      sample_stall;
  sample_t   sample = '0;
  logic      average_valid;
  logic      average_stall = 1'b0;
  sample_t   average;
  logic      window_log2_we = 1'b0;
  win_code_t window_log2 = WIN_2;

  bit idle_en = 1'b1;
  int quiet_cycles = 0;
  avg_scoreboard sb = new();

  moving_average_filter_core #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample        (sample),
    .average_valid (average_valid),
    .average_stall (average_stall),
    .average       (average),
    .window_log2_we(window_log2_we),
    .window_log2   (window_log2)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (average_valid && !average_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("moving_average_filter_core: mismatch");
        $finish;
      end
    end
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sample_t'(int'($urandom_range(0, 15)) - 8);
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic send_sample(sample_t x);
    int gap;
    gap = idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= x;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(x);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(win_code_t code);
    drain();
    window_log2_we <= 1'b1;
    window_log2 <= code;
    @(posedge clk);
    window_log2_we <= 1'b0;
    sb.set_window(code);
  endtask

  // result side
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = idle_en ? $urandom_range(0, 4) : 0;
      if (hold > 0) begin
        average_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      average_stall <= 1'b0;
      do @(posedge clk); while (!average_valid);
      sb.check_average(average);
    end
  end

  initial begin
    win_code_t phase_codes [5];
    win_code_t code;
    int n_items;
    phase_codes = '{WIN_8, WIN_4, WIN_UNUSED, WIN_2, WIN_2};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window of 2: extremes and truncation toward zero
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(-24'sd1);
    send_sample(24'sd0);
    send_sample(24'sd1);
    send_sample(24'sd0);

    // full window of 8 at both extremes, then wrap
    write_window(WIN_8);
    repeat (8) send_sample(SAMPLE_MIN);
    repeat (8) send_sample(SAMPLE_MAX);

    for (int p = 0; p < 10; p++) begin
      code = (p < 5) ? phase_codes[p] : win_code_t'($urandom_range(0, 3));
      write_window(code);
      idle_en = (p % 3 != 2);
      n_items = $urandom_range(40, 80);
      for (int i = 0; i < n_items; i++) send_sample(rand_sample());
    end
    idle_en = 1'b1;

    drain();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("moving_average_filter_core: match");
    end else begin
      $display("moving_average_filter_core: mismatch");
    end
    $finish;
  end

endmodule
